[rtl/core/bpcf_pkg.sv]
// ----------------------------------------------------------------------------
// bpcf_pkg
// Shared types and constants for the broad-phase box pair filter.
// ----------------------------------------------------------------------------
package bpcf_pkg;

	localparam int CAPACITY = 32;
	localparam int ID_BITS  = 16;

	localparam int ID_W    = ID_BITS;
	localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int COORD_W = 32;
	localparam int AXES    = 3;

	// port payload widths
	localparam int OBJ_ID_W    = 16;
	localparam int IN_TDATA_W  = 216;
	localparam int OUT_TDATA_W = 40;
	localparam int CFG_IDX_W   = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TERR_X_LO = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TERR_X_HI = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TERR_Y_LO = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TERR_Y_HI = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TERR_Z_LO = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TERR_Z_HI = 3'd5;

	localparam logic [COORD_W-1:0] TERR_LO_RST = 32'h8000_0000;
	localparam logic [COORD_W-1:0] TERR_HI_RST = 32'h7FFF_FFFF;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic             home;
		coord_t [AXES-1:0] mn;
		coord_t [AXES-1:0] mx;
	} obj_t;

	localparam int OBJ_W = $bits(obj_t);

	typedef struct packed {
		coord_t [AXES-1:0] lo;
		coord_t [AXES-1:0] hi;
	} terr_t;

	// compare pipeline status toward the sequencer
	typedef struct packed {
		logic            busy;
		logic            v;
		logic            hit;
		logic [ID_W-1:0] lo_id;
		logic [ID_W-1:0] hi_id;
	} cmp_res_t;

endpackage

[rtl/core/bpcf_ram.sv]
// ----------------------------------------------------------------------------
// bpcf_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bpcf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/bpcf_cmp.sv]
// ----------------------------------------------------------------------------
// bpcf_cmp
// Two-stage pair test of the current object against one stored entry.
// ----------------------------------------------------------------------------
module bpcf_cmp
	import bpcf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  logic     in_v,
	input  obj_t     cur,
	input  obj_t     ent,
	input  terr_t    terr,
	output cmp_res_t res
);

	logic              v_s2;
	logic              okid_s2;
	logic [AXES-1:0]   ov_s2;
	coord_t [AXES-1:0] m_s2;
	logic [ID_W-1:0]   lo_s2;
	logic [ID_W-1:0]   hi_s2;

	logic              v_s3;
	logic              hit_s3;
	logic [ID_W-1:0]   lo_s3;
	logic [ID_W-1:0]   hi_s3;

	logic              cur_lt;
	logic              okid_c;
	logic [AXES-1:0]   ov_c;
	coord_t [AXES-1:0] m_c;
	logic [AXES-1:0]   tr_c;

	// stage 2: id order, strict overlap, larger min corner
	always_comb begin
		cur_lt = cur.id < ent.id;
		okid_c = (cur.id != ent.id) && (cur_lt ? cur.home : ent.home);
		for (int a = 0; a < AXES; a++) begin
			ov_c[a] = ($signed(cur.mn[a]) < $signed(ent.mx[a])) &&
				($signed(ent.mn[a]) < $signed(cur.mx[a]));
			m_c[a] = ($signed(cur.mn[a]) > $signed(ent.mn[a])) ? cur.mn[a] : ent.mn[a];
		end
	end

	// stage 3: territory check of the corner
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			tr_c[a] = ($signed(m_s2[a]) >= $signed(terr.lo[a])) &&
				($signed(m_s2[a]) < $signed(terr.hi[a]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s2 <= in_v;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			okid_s2 <= okid_c;
			ov_s2   <= ov_c;
			m_s2    <= m_c;
			lo_s2   <= cur_lt ? cur.id : ent.id;
			hi_s2   <= cur_lt ? ent.id : cur.id;
			hit_s3  <= okid_s2 & (&ov_s2) & (&tr_c);
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
		end
	end

	assign res.busy  = v_s2 | v_s3;
	assign res.v     = v_s3;
	assign res.hit   = hit_s3;
	assign res.lo_id = lo_s3;
	assign res.hi_id = hi_s3;

endmodule

[rtl/core/bbox_pair_collision_filter.sv]
// ----------------------------------------------------------------------------
// bbox_pair_collision_filter
// Broad-phase box overlap filter for one grid cell, memory-based scan.
// ----------------------------------------------------------------------------
// Each accepted object is tested against every object stored for the cell,
// in storage order, and is written to the object memory as it is accepted
// if there is room. One result transaction goes out per reported pair, or a
// single no-pair result when nothing matches; tlast marks the final result
// of an object. The object memory has one read port, and the scan reads one
// entry per cycle, unless a stalled output holds it, through a read stage
// and a two-stage compare. Then the final result is flushed. The input is
// ready again in the cycle that result appears. A stalled output holds the
// scan. The memory needs no clearing after reset; a fill count tracks which
// entries are live.
module bbox_pair_collision_filter
	import bpcf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// s_tdata: new_cell, obj_id[16], is_home, x_min, x_max, y_min, y_max,
	//          z_min, z_max (32 each), zero pad
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// m_tdata: pair_valid, lower_id[16], upper_id[16], store_full, zero pad
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tlast,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [COORD_W-1:0]     cfg_data
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]       state_q;
	terr_t            terr_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] scan_n_q;
	logic [CNT_W-1:0] idx_q;
	logic             full_q;
	obj_t             cur_q;
	logic             rd_v_s1;

	logic             pend_v_q;
	logic [ID_W-1:0]  pend_lo_q;
	logic [ID_W-1:0]  pend_hi_q;

	logic                out_v_q;
	logic                out_pv_q;
	logic [OBJ_ID_W-1:0] out_lo_q;
	logic [OBJ_ID_W-1:0] out_hi_q;
	logic                out_full_q;
	logic                out_last_q;

	obj_t             in_obj;
	logic             in_new_cell;
	logic             in_take;
	logic [CNT_W-1:0] cnt_eff;
	logic             in_full;
	logic             out_free;
	logic             out_load;
	logic             hit_new;
	logic             adv;
	logic             issue;
	logic             scan_done;
	obj_t             ent;
	logic [OBJ_W-1:0] ram_rdata;
	cmp_res_t         cmp_res;

	// input unpacking
	always_comb begin
		in_new_cell  = s_tdata[0];
		in_obj.id    = ID_W'(s_tdata[16:1]);
		in_obj.home  = s_tdata[17];
		in_obj.mn[0] = s_tdata[49:18];
		in_obj.mx[0] = s_tdata[81:50];
		in_obj.mn[1] = s_tdata[113:82];
		in_obj.mx[1] = s_tdata[145:114];
		in_obj.mn[2] = s_tdata[177:146];
		in_obj.mx[2] = s_tdata[209:178];
	end

	assign s_tready  = (state_q == ST_IDLE);
	assign in_take   = s_tvalid && s_tready;
	assign cnt_eff   = in_new_cell ? '0 : cnt_q;
	assign in_full   = (cnt_eff == CNT_W'(CAPACITY));

	assign out_free  = !out_v_q || m_tready;
	assign hit_new   = cmp_res.v && cmp_res.hit;
	// a second hit while one is pending needs room in the output register
	assign adv       = (state_q == ST_SCAN) && !(hit_new && pend_v_q && !out_free);
	assign issue     = adv && (idx_q != scan_n_q);
	assign scan_done = (idx_q == scan_n_q) && !rd_v_s1 && !cmp_res.busy;
	assign out_load  = (adv && hit_new && pend_v_q) || ((state_q == ST_FLUSH) && out_free);

	assign ent = obj_t'(ram_rdata);

	bpcf_ram #(
		.WIDTH (OBJ_W),
		.DEPTH (CAPACITY)
	) u_obj_ram (
		.clk   (clk),
		.we    (in_take && !in_full),
		.waddr (cnt_eff[IDX_W-1:0]),
		.wdata (OBJ_W'(in_obj)),
		.re    (adv),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	bpcf_cmp u_cmp (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.in_v   (rd_v_s1),
		.cur    (cur_q),
		.ent    (ent),
		.terr   (terr_q),
		.res    (cmp_res)
	);

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				terr_q.lo[a] <= TERR_LO_RST;
				terr_q.hi[a] <= TERR_HI_RST;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TERR_X_LO: terr_q.lo[0] <= cfg_data;
				REG_TERR_X_HI: terr_q.hi[0] <= cfg_data;
				REG_TERR_Y_LO: terr_q.lo[1] <= cfg_data;
				REG_TERR_Y_HI: terr_q.hi[1] <= cfg_data;
				REG_TERR_Z_LO: terr_q.lo[2] <= cfg_data;
				REG_TERR_Z_HI: terr_q.hi[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and result control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			rd_v_s1  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						cnt_q   <= in_full ? cnt_eff : cnt_eff + CNT_W'(1);
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (adv) begin
						rd_v_s1 <= issue;
						if (hit_new) begin
							pend_v_q <= 1'b1;
						end
					end
					if (scan_done) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			cur_q    <= in_obj;
			full_q   <= in_full;
			scan_n_q <= cnt_eff;
			idx_q    <= '0;
		end
		if (issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		if (adv && hit_new) begin
			pend_lo_q <= cmp_res.lo_id;
			pend_hi_q <= cmp_res.hi_id;
			if (pend_v_q) begin
				out_pv_q   <= 1'b1;
				out_lo_q   <= OBJ_ID_W'(pend_lo_q);
				out_hi_q   <= OBJ_ID_W'(pend_hi_q);
				out_full_q <= full_q;
				out_last_q <= 1'b0;
			end
		end
		if ((state_q == ST_FLUSH) && out_free) begin
			out_pv_q   <= pend_v_q;
			out_lo_q   <= pend_v_q ? OBJ_ID_W'(pend_lo_q) : '0;
			out_hi_q   <= pend_v_q ? OBJ_ID_W'(pend_hi_q) : '0;
			out_full_q <= full_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'b0, out_full_q, out_hi_q, out_lo_q, out_pv_q};

endmodule

[rtl/core/bpcf_checker.sv]
// ----------------------------------------------------------------------------
// bpcf_checker
// Port-level checks for the box pair filter, bound to the top level.
// ----------------------------------------------------------------------------
module bpcf_checker
	import bpcf_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tlast
);

	// a stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result changed");

	// one object at a time: no input right after an accepted one
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// a no-pair result is always the only and final one
	a_nopair_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tlast && (m_tdata[32:1] == 32'd0))
		else $error("no-pair result not final or ids nonzero");

	// reported pairs are ordered by id
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> (m_tdata[16:1] < m_tdata[32:17]))
		else $error("pair ids not ordered");

endmodule

bind bbox_pair_collision_filter bpcf_checker u_bpcf_checker (.*);
